>>> rtl/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define APBF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("apbf assertion failed");

// condition in one cycle implies a consequence in the next
`define APBF_ASSERT_NEXT(lbl, ante, cons) \
	`APBF_ASSERT(lbl, (ante) |=> (cons))

`endif

>>> rtl/apbf_pkg.sv
package apbf_pkg;

	// default coordinate format
	localparam int COORD_INT_BITS_DEF  = 16;
	localparam int COORD_FRAC_BITS_DEF = 8;

	// width of the scale quotient, saturates at all ones
	localparam int QUOT_W = 64;

endpackage

>>> rtl/apbf_if.sv
// corner channel: four transformed rectangle corners per transaction
interface apbf_corner_if import apbf_pkg::*; #(
	parameter int CW = COORD_INT_BITS_DEF + COORD_FRAC_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] origin_x;
	logic signed [CW-1:0] origin_y;
	logic signed [CW-1:0] opposite_x;
	logic signed [CW-1:0] opposite_y;
	logic signed [CW-1:0] xside_x;
	logic signed [CW-1:0] xside_y;
	logic signed [CW-1:0] yside_x;
	logic signed [CW-1:0] yside_y;

	modport source (
		output valid, origin_x, origin_y, opposite_x, opposite_y,
		output xside_x, xside_y, yside_x, yside_y,
		input  ready
	);
	modport sink (
		input  valid, origin_x, origin_y, opposite_x, opposite_y,
		input  xside_x, xside_y, yside_x, yside_y,
		output ready
	);
endinterface

// box channel: rescaled box corners per transaction
interface apbf_box_if import apbf_pkg::*; #(
	parameter int CW = COORD_INT_BITS_DEF + COORD_FRAC_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] box_min_x;
	logic signed [CW-1:0] box_min_y;
	logic signed [CW-1:0] box_max_x;
	logic signed [CW-1:0] box_max_y;

	modport source (
		output valid, box_min_x, box_min_y, box_max_x, box_max_y,
		input  ready
	);
	modport sink (
		input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
		output ready
	);
endinterface

>>> rtl/apbf_isqrt.sv
// pipelined integer square root, one root bit per stage, several lanes in step
module apbf_isqrt #(
	parameter int IN_W  = 64,
	parameter int LANES = 2,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [IN_W-1:0]  in_x [LANES],
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [IN_W/2-1:0] out_root [LANES],
	output logic [SB_W-1:0]  out_sb
);

	localparam int N = IN_W / 2;

	logic [IN_W-1:0] x_s  [N][LANES];
	logic [N:0]      r_s  [N][LANES];
	logic [N-1:0]    q_s  [N][LANES];
	logic            v_s  [N];
	logic [SB_W-1:0] sb_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic            v_in;
		logic [SB_W-1:0] sb_in;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign sb_in = in_sb;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign sb_in = sb_s[k-1];
		end

		// valid travels with the data
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sb_in;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [IN_W-1:0] x_in;
			logic [N:0]      r_in;
			logic [N-1:0]    q_in;
			logic [N+2:0]    t;
			logic [N+2:0]    trial;
			logic [N:0]      r_nx;
			logic [N-1:0]    q_nx;

			if (k == 0) begin : g_first
				assign x_in = in_x[l];
				assign r_in = '0;
				assign q_in = '0;
			end else begin : g_next
				assign x_in = x_s[k-1][l];
				assign r_in = r_s[k-1][l];
				assign q_in = q_s[k-1][l];
			end

			// bring down two bits, try root bit one
			always_comb begin
				t     = {r_in, x_in[IN_W-1 -: 2]};
				trial = {1'b0, q_in, 2'b01};
				if (t >= trial) begin
					r_nx = (N+1)'(t - trial);
					q_nx = {q_in[N-2:0], 1'b1};
				end else begin
					r_nx = t[N:0];
					q_nx = {q_in[N-2:0], 1'b0};
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k][l] <= x_in << 2;
					r_s[k][l] <= r_nx;
					q_s[k][l] <= q_nx;
				end
			end

			assign out_root[l] = q_s[N-1][l];
		end
	end

	assign out_valid = v_s[N-1];
	assign out_sb    = sb_s[N-1];

endmodule

>>> rtl/apbf_div.sv
// pipelined restoring divider, one quotient bit per stage, shared divisor
module apbf_div #(
	parameter int QW    = 64,
	parameter int DEN_W = 49,
	parameter int LANES = 2,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DEN_W-1:0] in_rem [LANES],
	input  logic [QW-1:0]    in_num [LANES],
	input  logic [DEN_W-1:0] in_den,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [QW-1:0]    out_q [LANES],
	output logic [SB_W-1:0]  out_sb
);

	logic [DEN_W-1:0] rem_s [QW][LANES];
	logic [QW-1:0]    lq_s  [QW][LANES];
	logic [DEN_W-1:0] den_s [QW];
	logic             v_s   [QW];
	logic [SB_W-1:0]  sb_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic             v_in;
		logic [DEN_W-1:0] den_in;
		logic [SB_W-1:0]  sb_in;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign den_in = in_den;
			assign sb_in  = in_sb;
		end else begin : g_next
			assign v_in   = v_s[k-1];
			assign den_in = den_s[k-1];
			assign sb_in  = sb_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				sb_s[k]  <= sb_in;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DEN_W-1:0] rem_in;
			logic [QW-1:0]    lq_in;
			logic [DEN_W:0]   t;
			logic [DEN_W-1:0] rem_nx;
			logic             qbit;

			if (k == 0) begin : g_first
				assign rem_in = in_rem[l];
				assign lq_in  = in_num[l];
			end else begin : g_next
				assign rem_in = rem_s[k-1][l];
				assign lq_in  = lq_s[k-1][l];
			end

			// shift in the next dividend bit, subtract when it fits
			always_comb begin
				t = {rem_in, lq_in[QW-1]};
				if (t >= {1'b0, den_in}) begin
					rem_nx = DEN_W'(t - {1'b0, den_in});
					qbit   = 1'b1;
				end else begin
					rem_nx = t[DEN_W-1:0];
					qbit   = 1'b0;
				end
			end

			// dividend bits leave at the top as quotient bits enter at the bottom
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= rem_nx;
					lq_s[k][l]  <= {lq_in[QW-2:0], qbit};
				end
			end

			assign out_q[l] = lq_s[QW-1][l];
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_sb    = sb_s[QW-1];

endmodule

>>> rtl/area_preserving_box_fit.sv
// pipeline from corner transaction to box transaction: 3 front stages, CW+1
// edge-length root stages, 3 product stages, 64 divider stages, 32 scale root
// stages and the output register; throughput: one transaction per cycle while the
// box output is not stalled, the whole pipeline advances together
// reset clears only the stage valid bits; payload registers are not reset
module area_preserving_box_fit import apbf_pkg::*; #(
	parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	apbf_corner_if.sink   corners,
	apbf_box_if.source    box
);

	localparam int CW   = COORD_INT_BITS + COORD_FRAC_BITS;
	localparam int LW   = CW + 1;
	localparam int SQW  = 2 * CW + 2;
	localparam int NW   = 2 * CW + 2;
	localparam int DENW = 2 * CW + 1;
	localparam int AW   = 2 * CW + 4;
	localparam int AH   = AW / 2;
	localparam int BH   = NW / 2;
	localparam int PPW  = AH + BH;
	localparam int PW   = AW + NW;
	localparam int PRW  = (PW > QUOT_W) ? PW : QUOT_W + 1;
	localparam int HIW  = PRW - QUOT_W;
	localparam int CMPW = (HIW > DENW) ? HIW : DENW;
	localparam int UW   = QUOT_W / 2;
	localparam int EW   = ((CW + 3 > UW + 1) ? CW + 3 : UW + 1) + 2;
	localparam int SBA_W = 4 * CW + DENW + 2 * (CW + 1);
	localparam int SBD_W = 2 + 2 * (CW + 1);
	localparam int SBU_W = 2 * (CW + 1);

	localparam logic [NW-1:0]   ONE_N = NW'(1) << (2 * COORD_FRAC_BITS);
	localparam logic [DENW-1:0] ONE_D = DENW'(1) << (2 * COORD_FRAC_BITS);
	localparam logic signed [EW-1:0] FOUR_E = 4;
	localparam logic signed [EW-1:0] SAT_HI = {{(EW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

	function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [CW-1:0] mag_of(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [CW:0] d;
		d = (CW+1)'(a) - (CW+1)'(b);
		return d[CW] ? CW'(-d) : d[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] sat_cw(input logic signed [EW-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[CW-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

	// global advance: the output register is empty or being taken
	logic out_v_q;
	logic en;

	assign en            = !out_v_q || box.ready;
	assign corners.ready = en;

	// stage 1: edge component magnitudes and bounding box
	logic                 v_s1;
	logic [CW-1:0]        m1x_s1, m1y_s1, m2x_s1, m2y_s1;
	logic signed [CW-1:0] minx_s1, maxx_s1, miny_s1, maxy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= corners.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1x_s1  <= mag_of(corners.xside_x, corners.origin_x);
			m1y_s1  <= mag_of(corners.xside_y, corners.origin_y);
			m2x_s1  <= mag_of(corners.yside_x, corners.origin_x);
			m2y_s1  <= mag_of(corners.yside_y, corners.origin_y);
			minx_s1 <= smin(smin(corners.origin_x, corners.opposite_x),
				smin(corners.xside_x, corners.yside_x));
			maxx_s1 <= smax(smax(corners.origin_x, corners.opposite_x),
				smax(corners.xside_x, corners.yside_x));
			miny_s1 <= smin(smin(corners.origin_y, corners.opposite_y),
				smin(corners.xside_y, corners.yside_y));
			maxy_s1 <= smax(smax(corners.origin_y, corners.opposite_y),
				smax(corners.xside_y, corners.yside_y));
		end
	end

	// stage 2: squares of the components, spans and center sums
	logic                 v_s2;
	logic [2*CW-1:0]      q1x_s2, q1y_s2, q2x_s2, q2y_s2;
	logic [CW-1:0]        spanx_s2, spany_s2;
	logic signed [CW:0]   csx_s2, csy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q1x_s2   <= (2*CW)'(m1x_s1) * (2*CW)'(m1x_s1);
			q1y_s2   <= (2*CW)'(m1y_s1) * (2*CW)'(m1y_s1);
			q2x_s2   <= (2*CW)'(m2x_s1) * (2*CW)'(m2x_s1);
			q2y_s2   <= (2*CW)'(m2y_s1) * (2*CW)'(m2y_s1);
			spanx_s2 <= CW'(maxx_s1 - minx_s1);
			spany_s2 <= CW'(maxy_s1 - miny_s1);
			csx_s2   <= (CW+1)'(minx_s1) + (CW+1)'(maxx_s1);
			csy_s2   <= (CW+1)'(miny_s1) + (CW+1)'(maxy_s1);
		end
	end

	// stage 3: squared edge lengths, squared spans and box area plus one
	logic                 v_s3;
	logic [SQW-1:0]       ss_s3 [2];
	logic [2*CW-1:0]      spsqx_s3, spsqy_s3;
	logic [DENW-1:0]      den_s3;
	logic signed [CW:0]   csx_s3, csy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s3[0] <= SQW'(q1x_s2) + SQW'(q1y_s2);
			ss_s3[1] <= SQW'(q2x_s2) + SQW'(q2y_s2);
			spsqx_s3 <= (2*CW)'(spanx_s2) * (2*CW)'(spanx_s2);
			spsqy_s3 <= (2*CW)'(spany_s2) * (2*CW)'(spany_s2);
			den_s3   <= DENW'((2*CW)'(spanx_s2) * (2*CW)'(spany_s2)) + ONE_D;
			csx_s3   <= csx_s2;
			csy_s3   <= csy_s2;
		end
	end

	// edge lengths
	logic                 len_v;
	logic [LW-1:0]        len [2];
	logic [SBA_W-1:0]     len_sb;
	logic [2*CW-1:0]      spsqx_l, spsqy_l;
	logic [DENW-1:0]      den_l;
	logic signed [CW:0]   csx_l, csy_l;

	apbf_isqrt #(
		.IN_W  (SQW),
		.LANES (2),
		.SB_W  (SBA_W)
	) u_len_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_x      (ss_s3),
		.in_sb     ({spsqx_s3, spsqy_s3, den_s3, csx_s3, csy_s3}),
		.out_valid (len_v),
		.out_root  (len),
		.out_sb    (len_sb)
	);

	assign {spsqx_l, spsqy_l, den_l, csx_l, csy_l} = len_sb;

	// stage 4: shape area plus one, scaled squared spans
	logic                 v_s4;
	logic [NW-1:0]        num_s4;
	logic [AW-1:0]        a_s4 [2];
	logic [DENW-1:0]      den_s4;
	logic signed [CW:0]   cs_s4 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= len_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4   <= NW'(len[0]) * NW'(len[1]) + ONE_N;
			a_s4[0]  <= {spsqx_l, 4'b0000};
			a_s4[1]  <= {spsqy_l, 4'b0000};
			den_s4   <= den_l;
			cs_s4[0] <= csx_l;
			cs_s4[1] <= csy_l;
		end
	end

	// stage 5: partial products of span term times area term
	logic                 v_s5;
	logic [PPW-1:0]       pll_s5 [2], plh_s5 [2], phl_s5 [2], phh_s5 [2];
	logic [DENW-1:0]      den_s5;
	logic signed [CW:0]   cs_s5 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				pll_s5[i] <= PPW'(a_s4[i][AH-1:0]) * PPW'(num_s4[BH-1:0]);
				plh_s5[i] <= PPW'(a_s4[i][AH-1:0]) * PPW'(num_s4[NW-1:BH]);
				phl_s5[i] <= PPW'(a_s4[i][AW-1:AH]) * PPW'(num_s4[BH-1:0]);
				phh_s5[i] <= PPW'(a_s4[i][AW-1:AH]) * PPW'(num_s4[NW-1:BH]);
				cs_s5[i]  <= cs_s4[i];
			end
			den_s5 <= den_s4;
		end
	end

	// stage 6: full dividend
	logic                 v_s6;
	logic [PRW-1:0]       prod_s6 [2];
	logic [DENW-1:0]      den_s6;
	logic signed [CW:0]   cs_s6 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				prod_s6[i] <= PRW'(pll_s5[i]) + (PRW'(plh_s5[i]) << BH)
					+ (PRW'(phl_s5[i]) << AH) + (PRW'(phh_s5[i]) << (AH + BH));
				cs_s6[i]   <= cs_s5[i];
			end
			den_s6 <= den_s5;
		end
	end

	// overflow check on the upper half and divider start values
	logic [HIW-1:0]  hi_w   [2];
	logic            sat_w  [2];
	logic [DENW-1:0] rem_w  [2];
	logic [QUOT_W-1:0] lo_w [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			hi_w[i]  = prod_s6[i][PRW-1:QUOT_W];
			sat_w[i] = CMPW'(hi_w[i]) >= CMPW'(den_s6);
			rem_w[i] = DENW'(hi_w[i]);
			lo_w[i]  = prod_s6[i][QUOT_W-1:0];
		end
	end

	logic              div_v;
	logic [QUOT_W-1:0] quo [2];
	logic [SBD_W-1:0]  div_sb;
	logic              sat_d [2];
	logic signed [CW:0] cs_d [2];

	apbf_div #(
		.QW    (QUOT_W),
		.DEN_W (DENW),
		.LANES (2),
		.SB_W  (SBD_W)
	) u_scale_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_rem    (rem_w),
		.in_num    (lo_w),
		.in_den    (den_s6),
		.in_sb     ({sat_w[0], sat_w[1], cs_s6[0], cs_s6[1]}),
		.out_valid (div_v),
		.out_q     (quo),
		.out_sb    (div_sb)
	);

	assign {sat_d[0], sat_d[1], cs_d[0], cs_d[1]} = div_sb;

	// saturated quotient into the half-width root
	logic [QUOT_W-1:0] qs [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qs[i] = sat_d[i] ? '1 : quo[i];
		end
	end

	logic               hw_v;
	logic [UW-1:0]      hw [2];
	logic [SBU_W-1:0]   hw_sb;
	logic signed [CW:0] cs_u [2];

	apbf_isqrt #(
		.IN_W  (QUOT_W),
		.LANES (2),
		.SB_W  (SBU_W)
	) u_half_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_v),
		.in_x      (qs),
		.in_sb     ({cs_d[0], cs_d[1]}),
		.out_valid (hw_v),
		.out_root  (hw),
		.out_sb    (hw_sb)
	);

	assign {cs_u[0], cs_u[1]} = hw_sb;

	// edges: rounded center minus and plus half-width, saturated
	logic signed [EW-1:0] mid_e [2], rad_e [2], lo_e [2], hi_e [2];
	logic [CW-1:0]        emin [2], emax [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mid_e[i] = EW'(cs_u[i]) <<< 2;
			rad_e[i] = EW'($signed({1'b0, hw[i]}));
			lo_e[i]  = (mid_e[i] - rad_e[i] + FOUR_E) >>> 3;
			hi_e[i]  = (mid_e[i] + rad_e[i] + FOUR_E) >>> 3;
			emin[i]  = sat_cw(lo_e[i]);
			emax[i]  = sat_cw(hi_e[i]);
		end
	end

	// output register
	logic [CW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= hw_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			min_x_q <= emin[0];
			min_y_q <= emin[1];
			max_x_q <= emax[0];
			max_y_q <= emax[1];
		end
	end

	assign box.valid     = out_v_q;
	assign box.box_min_x = min_x_q;
	assign box.box_min_y = min_y_q;
	assign box.box_max_x = max_x_q;
	assign box.box_max_y = max_y_q;

endmodule

>>> rtl/apbf_check.sv
`include "assert_macros.svh"

// port-level checks on the box fit
module apbf_check #(
	parameter int CW = 24
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [CW-1:0] min_x,
	input logic signed [CW-1:0] min_y,
	input logic signed [CW-1:0] max_x,
	input logic signed [CW-1:0] max_y
);

	// the pipeline takes a transaction whenever its output can move
	`APBF_ASSERT(a_ready_tracks_out, in_ready == (!out_valid || out_ready))

	// a stalled box transaction keeps its valid, min_x and max_y
	`APBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(min_x) && $stable(max_y))

	// rescaling about the center never crosses the edges
	`APBF_ASSERT(a_x_order, out_valid |-> (min_x <= max_x))
	`APBF_ASSERT(a_y_order, out_valid |-> (min_y <= max_y))

	// corner valid is at a known level outside reset
	`APBF_ASSERT(a_in_valid_known, !$isunknown(in_valid))

endmodule

bind area_preserving_box_fit apbf_check #(.CW(CW)) u_apbf_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (corners.valid),
	.in_ready  (corners.ready),
	.out_valid (box.valid),
	.out_ready (box.ready),
	.min_x     (box.box_min_x),
	.min_y     (box.box_min_y),
	.max_x     (box.box_max_x),
	.max_y     (box.box_max_y)
);
